[src/aescfb_pkg.sv]
// shared types, constants and round functions for the aes-256 cfb byte cipher
package aescfb_pkg;

   localparam int RkDepth = 30;
   localparam int RkWidth = 64;
   localparam int RkAddrW = $clog2(RkDepth);
   localparam logic [3:0] LastRound = 4'd14;
   localparam logic [5:0] LastSchedWord = 6'd59;
   localparam logic [5:0] FirstSchedWord = 6'd8;

   localparam logic [2:0] CsrKey0 = 3'd0;
   localparam logic [2:0] CsrKey1 = 3'd1;
   localparam logic [2:0] CsrKey2 = 3'd2;
   localparam logic [2:0] CsrKey3 = 3'd3;
   localparam logic [2:0] CsrIvUpper = 3'd4;
   localparam logic [2:0] CsrIvLower = 3'd5;
   localparam logic [2:0] CsrMode = 3'd6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_KEY_LOAD,
      ST_KEY_EXP,
      ST_AES_START,
      ST_AES_HI,
      ST_AES_RND,
      ST_EMIT
   } state_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] RCON [8] = '{
      8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40
   };

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   // one round without the key add (mixcolumns left out when last is set); byte 0 sits in the top bits
   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
      logic [7:0] b [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, all;
      logic [127:0] r;
      for (int i = 0; i < 16; i++) begin
         b[i] = SBOX[s[127-8*i -: 8]];
      end
      for (int c = 0; c < 4; c++) begin
         for (int k = 0; k < 4; k++) begin
            t[4*c+k] = b[4*((c+k)&3)+k];
         end
      end
      if (!last) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            all = a0 ^ a1 ^ a2 ^ a3;
            t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
            t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
            t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
            t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
         end
      end
      for (int i = 0; i < 16; i++) begin
         r[127-8*i -: 8] = t[i];
      end
      return r;
   endfunction

endpackage

[src/aescfb_ram.sv]
// generic single-write, single-read ram with registered read data
module aescfb_ram #(
   parameter int Width = 64,
   parameter int Depth = 30
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/aes256_cfb_stream_cipher_core.sv]
// aes-256 cfb128 byte stream cipher, top level
//
// encrypts or decrypts one byte per word in aes-256 cfb128 mode. key,
// iv and direction are set through the csr write channel (index 0..3 key
// words, first key byte in bits 63:56 of index 0; 4..5 iv, byte 0 in bits
// 63:56 of index 4; 6 decrypt mode). key and iv are taken up at the first
// byte of a message, the mode at each byte; a word with tlast high ends
// the message and the next byte restarts from the iv. the round-key
// schedule lives in a 30 x 64 ram and is rebuilt at every message start:
// the key is copied into entries 0..3, then the expansion loop makes
// schedule words 8..59 and writes them in pairs. the block cipher is an
// iterative round unit fed from that ram, the round key read in two
// halves. a new byte is taken only while the block is idle, after the last
// byte's result has gone to the output register, so the next byte is taken
// while that result still waits.
module aes256_cfb_stream_cipher_core
   import aescfb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // end_of_message
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] result_byte
   output logic        rsp_tlast,   // is_last
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   // configuration registers
   logic [63:0] key_ff [4];
   logic [63:0] iv_upper_ff, iv_lower_ff;
   logic        decrypt_ff;

   // control
   state_type   state_ff, state_in;
   logic        fresh_ff, fresh_in;
   logic [3:0]  pos_ff, pos_in;
   logic [5:0]  cnt_ff, cnt_in;      // key copy index, schedule word index
   logic [3:0]  round_ff, round_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // datapath
   logic [127:0] fb_ff, fb_in;       // feedback block
   logic [127:0] ks_ff, ks_in;       // keystream block
   logic [127:0] st_ff, st_in;       // cipher state
   logic [63:0]  rk_hi_ff, rk_hi_in;
   logic [31:0]  win_ff [8];         // last eight schedule words
   logic [31:0]  win_in [8];
   logic [7:0]   din_ff, din_in;
   logic         eom_ff, eom_in;
   logic [7:0]   rsp_data_ff, rsp_data_in;
   logic         rsp_last_ff, rsp_last_in;

   // round-key ram
   logic               rk_wr_en;
   logic [RkAddrW-1:0] rk_wr_addr;
   logic [RkWidth-1:0] rk_wr_data;
   logic [RkAddrW-1:0] rk_rd_addr;
   logic [RkWidth-1:0] rk_rd_data;

   logic [31:0]  sched_t;
   logic [31:0]  sched_new;
   logic [127:0] round_out;
   logic [7:0]   ks_byte;
   logic [7:0]   res_byte;
   logic         out_free;

   aescfb_ram #(
      .Width(RkWidth),
      .Depth(RkDepth)
   ) u_rk_ram (
      .clock  (clock),
      .wr_en  (rk_wr_en),
      .wr_addr(rk_wr_addr),
      .wr_data(rk_wr_data),
      .rd_addr(rk_rd_addr),
      .rd_data(rk_rd_data)
   );

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            key_ff[i] <= '0;
         end
         iv_upper_ff <= '0;
         iv_lower_ff <= '0;
         decrypt_ff  <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CsrKey0:    key_ff[0] <= csr_data;
            CsrKey1:    key_ff[1] <= csr_data;
            CsrKey2:    key_ff[2] <= csr_data;
            CsrKey3:    key_ff[3] <= csr_data;
            CsrIvUpper: iv_upper_ff <= csr_data;
            CsrIvLower: iv_lower_ff <= csr_data;
            CsrMode:    decrypt_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // schedule step: w[i] = w[i-8] ^ f(w[i-1])
   always_comb begin
      sched_t = win_ff[7];
      if (cnt_ff[2:0] == 3'd0) begin
         sched_t = sub_word({win_ff[7][23:0], win_ff[7][31:24]}) ^
                   {RCON[cnt_ff[5:3]], 24'h0};
      end else if (cnt_ff[2:0] == 3'd4) begin
         sched_t = sub_word(win_ff[7]);
      end
      sched_new = win_ff[0] ^ sched_t;
   end

   assign round_out = aes_round(st_ff, round_ff == LastRound);
   assign ks_byte   = ks_ff[127 - 8*pos_ff -: 8];
   assign res_byte  = din_ff ^ ks_byte;
   assign out_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      fresh_in     = fresh_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      round_in     = round_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      fb_in        = fb_ff;
      ks_in        = ks_ff;
      st_in        = st_ff;
      rk_hi_in     = rk_hi_ff;
      win_in       = win_ff;
      din_in       = din_ff;
      eom_in       = eom_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rk_wr_en     = 1'b0;
      rk_wr_addr   = cnt_ff[RkAddrW-1:0];
      rk_wr_data   = key_ff[cnt_ff[1:0]];
      rk_rd_addr   = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               din_in = req_tdata;
               eom_in = req_tlast;
               if (fresh_ff) begin
                  // message start: take up iv and key
                  fresh_in = 1'b0;
                  pos_in   = '0;
                  fb_in    = {iv_upper_ff, iv_lower_ff};
                  for (int j = 0; j < 8; j++) begin
                     win_in[j] = key_ff[j/2][63 - 32*(j%2) -: 32];
                  end
                  cnt_in   = '0;
                  state_in = ST_KEY_LOAD;
               end else if (pos_ff == 4'd0) begin
                  state_in = ST_AES_START;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_KEY_LOAD: begin
            // entries 0..3 are the key itself
            rk_wr_en = 1'b1;
            if (cnt_ff[1:0] == 2'd3) begin
               cnt_in   = FirstSchedWord;
               state_in = ST_KEY_EXP;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         ST_KEY_EXP: begin
            for (int j = 0; j < 7; j++) begin
               win_in[j] = win_ff[j+1];
            end
            win_in[7]  = sched_new;
            rk_wr_en   = cnt_ff[0];
            rk_wr_addr = cnt_ff[5:1];
            rk_wr_data = {win_ff[7], sched_new};
            if (cnt_ff == LastSchedWord) begin
               state_in = ST_AES_START;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         ST_AES_START: begin
            st_in      = fb_ff;
            round_in   = '0;
            rk_rd_addr = '0;
            state_in   = ST_AES_HI;
         end
         ST_AES_HI: begin
            rk_hi_in   = rk_rd_data;
            rk_rd_addr = {round_ff, 1'b1};
            state_in   = ST_AES_RND;
         end
         ST_AES_RND: begin
            if (round_ff == 4'd0) begin
               st_in = st_ff ^ {rk_hi_ff, rk_rd_data};
            end else begin
               st_in = round_out ^ {rk_hi_ff, rk_rd_data};
            end
            if (round_ff == LastRound) begin
               ks_in    = st_in;
               state_in = ST_EMIT;
            end else begin
               round_in   = round_ff + 4'd1;
               rk_rd_addr = {round_in, 1'b0};
               state_in   = ST_AES_HI;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_byte;
               rsp_last_in  = eom_ff;
               fb_in[127 - 8*pos_ff -: 8] = decrypt_ff ? din_ff : res_byte;
               pos_in = pos_ff + 4'd1;
               if (eom_ff) begin
                  fresh_in = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fresh_ff     <= 1'b1;
         pos_ff       <= '0;
         cnt_ff       <= '0;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         fb_ff        <= '0;
         ks_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         fresh_ff     <= fresh_in;
         pos_ff       <= pos_in;
         cnt_ff       <= cnt_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
         fb_ff        <= fb_in;
         ks_ff        <= ks_in;
      end
   end

   always_ff @(posedge clock) begin
      st_ff       <= st_in;
      rk_hi_ff    <= rk_hi_in;
      win_ff      <= win_in;
      din_ff      <= din_in;
      eom_ff      <= eom_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

[verif/tb.sv]
// testbench for the aes-256 cfb128 byte stream cipher: predicted bytes vs block output
`timescale 1ns / 1ps

module tb;
   import aescfb_pkg::*;

   // register index that maps to no register
   localparam logic [2:0] CsrUnused = 3'd7;

   // expected result word
   typedef struct packed {
      logic [7:0] result_byte;
      logic       is_last;
   } cipher_word_type;

   // keeps the predicted cipher state and the queue of bytes still owed
   class cfb_scoreboard;
      logic [63:0] key_reg [4];
      logic [63:0] iv_reg [2];
      logic        decrypt;
      logic [31:0] sched [60];
      logic [127:0] fb_blk;
      logic [127:0] ks_blk;
      logic [3:0]  pos;
      bit          fresh;
      cipher_word_type owed [$];
      int          errors;
      int          checked;
      int          messages;

      function new();
         for (int i = 0; i < 4; i++) key_reg[i] = '0;
         iv_reg[0] = '0;
         iv_reg[1] = '0;
         decrypt = 1'b0;
         fb_blk = '0;
         ks_blk = '0;
         pos = '0;
         fresh = 1'b1;
         errors = 0;
         checked = 0;
         messages = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [63:0] val);
         case (idx)
            CsrKey0: key_reg[0] = val;
            CsrKey1: key_reg[1] = val;
            CsrKey2: key_reg[2] = val;
            CsrKey3: key_reg[3] = val;
            CsrIvUpper: iv_reg[0] = val;
            CsrIvLower: iv_reg[1] = val;
            CsrMode: decrypt = val[0];
            default: ;
         endcase
      endfunction

      function logic [31:0] sbox_word(logic [31:0] w);
         return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
      endfunction

      function logic [7:0] dbl(logic [7:0] b);
         return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
      endfunction

      function void build_schedule();
         logic [31:0] t;
         for (int i = 0; i < 8; i++)
            sched[i] = i[0] ? key_reg[i/2][31:0] : key_reg[i/2][63:32];
         for (int i = 8; i < 60; i++) begin
            t = sched[i-1];
            if (i % 8 == 0)
               t = sbox_word({t[23:0], t[31:24]}) ^ {RCON[i/8], 24'h0};
            else if (i % 8 == 4)
               t = sbox_word(t);
            sched[i] = sched[i-8] ^ t;
         end
      endfunction

      // full 14-round block encryption, byte 0 in bits 127:120
      function logic [127:0] encrypt_block(logic [127:0] blk);
         logic [7:0] s [16];
         logic [7:0] t [16];
         logic [7:0] a0, a1, a2, a3, all;
         logic [127:0] r;
         for (int i = 0; i < 16; i++)
            s[i] = blk[127-8*i -: 8] ^ sched[i/4][31-8*(i%4) -: 8];
         for (int rnd = 1; rnd <= 14; rnd++) begin
            for (int i = 0; i < 16; i++) t[i] = SBOX[s[i]];
            for (int c = 0; c < 4; c++)
               for (int k = 0; k < 4; k++) s[4*c+k] = t[4*((c+k)&3)+k];
            if (rnd != 14) begin
               for (int c = 0; c < 4; c++) begin
                  a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                  all = a0 ^ a1 ^ a2 ^ a3;
                  s[4*c]   = a0 ^ all ^ dbl(a0 ^ a1);
                  s[4*c+1] = a1 ^ all ^ dbl(a1 ^ a2);
                  s[4*c+2] = a2 ^ all ^ dbl(a2 ^ a3);
                  s[4*c+3] = a3 ^ all ^ dbl(a3 ^ a0);
               end
            end
            for (int i = 0; i < 16; i++)
               s[i] = s[i] ^ sched[rnd*4 + i/4][31-8*(i%4) -: 8];
         end
         for (int i = 0; i < 16; i++) r[127-8*i -: 8] = s[i];
         return r;
      endfunction

      function void note_byte(logic [7:0] din, logic eom);
         cipher_word_type w;
         logic [7:0] ks;
         if (fresh) begin
            build_schedule();
            fb_blk = {iv_reg[0], iv_reg[1]};
            pos = '0;
            fresh = 1'b0;
         end
         if (pos == 0) ks_blk = encrypt_block(fb_blk);
         ks = ks_blk[127-8*pos -: 8];
         w.result_byte = din ^ ks;
         w.is_last = eom;
         fb_blk[127-8*pos -: 8] = decrypt ? din : w.result_byte;
         pos = pos + 4'd1;
         if (eom) begin
            fresh = 1'b1;
            messages++;
         end
         owed.push_back(w);
      endfunction

      function void check_word(logic [7:0] dout, logic last);
         cipher_word_type e;
         checked++;
         if (owed.size() == 0) begin
            $display("%0t: unexpected word byte=%02h last=%b", $time, dout, last);
            errors++;
            return;
         end
         e = owed.pop_front();
         if (dout !== e.result_byte) begin
            $display("%0t: result_byte expected %02h actual %02h", $time, e.result_byte, dout);
            errors++;
         end
         if (last !== e.is_last) begin
            $display("%0t: is_last expected %b actual %b", $time, e.is_last, last);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [63:0] csr_data;

   cfb_scoreboard sb;
   int send_idle_pct;
   int recv_stall_pct;
   int bytes_sent;

   aes256_cfb_stream_cipher_core DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // result side: random stall, check on every accepted word
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata, rsp_tlast);
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // valid stays high after the write; the next byte or a drain lowers it
   task automatic write_csr(logic [2:0] idx, logic [63:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, val);
   endtask

   // valid stays high after the byte; an idle cycle or a drain lowers it
   task automatic send_byte(logic [7:0] b, logic eom);
      csr_valid <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= eom;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_byte(b, eom);
      bytes_sent++;
   endtask

   // block idle: all results in, plus slack for any work still running
   task automatic drain();
      req_tvalid <= 1'b0;
      csr_valid <= 1'b0;
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic send_message(int len);
      for (int i = 0; i < len; i++)
         send_byte(8'($urandom_range(255)), i == len - 1);
   endtask

   task automatic random_settings();
      for (int i = 0; i < 6; i++)
         write_csr(3'(i), {$urandom, $urandom});
      write_csr(CsrMode, 64'($urandom_range(1)));
   endtask

   initial begin
      #2000000000;
      $display("aes256_cfb_stream_cipher_core test failed");
      $finish;
   end

   initial begin
      sb = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      csr_valid = 1'b0;
      csr_index = CsrKey0;
      csr_data = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      bytes_sent = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, extreme bytes, partial block then restart
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b1);
      drain();
      // all-ones key and iv, 17-byte message crossing a block edge
      for (int i = 0; i < 6; i++) write_csr(3'(i), '1);
      write_csr(CsrMode, 64'd0);
      for (int i = 0; i < 17; i++) send_byte(i[0] ? 8'hff : 8'h00, i == 16);
      drain();
      // decrypt mode, single-byte message, unknown register index ignored
      write_csr(CsrMode, 64'd1);
      write_csr(CsrUnused, '1);
      send_byte(8'ha5, 1'b1);
      // key/iv/mode change mid-message: wait for idle, then write between bytes
      send_byte(8'h5a, 1'b0);
      drain();
      write_csr(CsrKey0, 64'h0123456789abcdef);
      write_csr(CsrIvUpper, 64'hfedcba9876543210);
      write_csr(CsrMode, 64'd0);
      send_byte(8'h3c, 1'b0);
      send_byte(8'hc3, 1'b1);
      drain();

      // random: four idle phases, new settings each message group
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
            default: begin send_idle_pct = 34; recv_stall_pct = 34; end
         endcase
         for (int g = 0; g < 4; g++) begin
            if (g == 0 && ph == 0) begin
               for (int i = 0; i < 6; i++) write_csr(3'(i), '0);
            end else begin
               random_settings();
            end
            for (int m = 0; m < 4; m++)
               send_message(($urandom_range(9) == 0) ? $urandom_range(33, 48)
                                                     : $urandom_range(1, 24));
            // a mid-message mode write
            send_byte(8'($urandom_range(255)), 1'b0);
            drain();
            write_csr(CsrMode, 64'($urandom_range(1)));
            send_message($urandom_range(1, 5));
            drain();
         end
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
      drain();

      $display("covered %0d bytes in %0d messages, %0d words checked",
               bytes_sent, sb.messages, sb.checked);
      $display("settings: reset, all-ones, zero and random keys/ivs, both modes");
      if (sb.errors == 0 && sb.owed.size() == 0) begin
         $display("aes256_cfb_stream_cipher_core test passed");
      end else begin
         $display("aes256_cfb_stream_cipher_core test failed");
      end
      $finish;
   end

endmodule
